// ----- hdl/bigi_pkg.sv -----
// Shared widths, constants and types of the bilinear slowness interpolator.
package bigi_pkg;

    localparam int SLOW_W = 20;
    localparam int RAD_W  = 21;
    localparam int ANG_W  = 20;
    localparam int GRAD_W = 32;
    localparam int NUM_W  = 65;
    localparam int DEN_W  = 43;
    localparam int MAG_W  = 42;
    localparam int QUO_W  = 32;
    localparam int REM_W  = MAG_W + QUO_W;
    localparam int LANES  = 3;

    localparam int LANE_SLOW = 0;
    localparam int LANE_GR   = 1;
    localparam int LANE_GA   = 2;

    localparam int LANE_SHIFT [LANES] = '{0, 16, 20};

    localparam logic [SLOW_W-1:0] SLOW_MAX = '1;
    localparam logic [GRAD_W-1:0] GRAD_MAX = {1'b0, {(GRAD_W-1){1'b1}}};
    localparam logic [GRAD_W-1:0] GRAD_MIN = {1'b1, {(GRAD_W-1){1'b0}}};

    typedef logic signed [NUM_W-1:0] t_num;
    typedef logic signed [DEN_W-1:0] t_den;

    typedef struct packed {
        logic [SLOW_W-1:0] slow_upper_left;
        logic [SLOW_W-1:0] slow_upper_right;
        logic [SLOW_W-1:0] slow_lower_left;
        logic [SLOW_W-1:0] slow_lower_right;
        logic [RAD_W-1:0]  radius_upper;
        logic [RAD_W-1:0]  radius_lower;
        logic [ANG_W-1:0]  angle_left;
        logic [ANG_W-1:0]  angle_right;
        logic [RAD_W-1:0]  point_radius;
        logic [ANG_W-1:0]  point_angle;
    } t_query;

endpackage

// ----- hdl/bigi_front.sv -----
// Five-stage front end: cell extents, weights, products and the three numerators.
module bigi_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  bigi_pkg::t_query i_query,
    output logic             o_valid,
    output bigi_pkg::t_num   o_num [bigi_pkg::LANES],
    output bigi_pkg::t_den   o_den,
    output logic             o_fault
);
    import bigi_pkg::*;

    logic [4:0] r_v;

    logic signed [21:0] r1_dr, r1_wrl, r1_wrh;
    logic signed [20:0] r1_da, r1_wal, r1_wah;
    logic signed [20:0] r1_dgr_h, r1_dgr_l, r1_dga_h, r1_dga_l;
    logic [SLOW_W-1:0]  r1_slow [4];
    logic               r1_fault;

    logic signed [42:0] r2_den;
    logic signed [42:0] r2_w [4];
    logic signed [42:0] r2_gr1, r2_gr2, r2_ga1, r2_ga2;
    logic [SLOW_W-1:0]  r2_slow [4];
    logic               r2_fault;

    logic signed [41:0] r3_ph [4];
    logic signed [43:0] r3_pl [4];
    logic signed [43:0] r3_gr, r3_ga;
    t_den               r3_den;
    logic               r3_fault;

    logic signed [43:0] r4_hs, r4_gr, r4_ga;
    logic signed [45:0] r4_ls;
    t_den               r4_den;
    logic               r4_fault;

    t_num               r5_num [LANES];
    t_den               r5_den;
    logic               r5_fault;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_dr    <= $signed({1'b0, i_query.radius_upper}) - $signed({1'b0, i_query.radius_lower});
            r1_da    <= $signed({1'b0, i_query.angle_right}) - $signed({1'b0, i_query.angle_left});
            r1_wal   <= $signed({1'b0, i_query.angle_right}) - $signed({1'b0, i_query.point_angle});
            r1_wah   <= $signed({1'b0, i_query.point_angle}) - $signed({1'b0, i_query.angle_left});
            r1_wrl   <= $signed({1'b0, i_query.radius_upper}) - $signed({1'b0, i_query.point_radius});
            r1_wrh   <= $signed({1'b0, i_query.point_radius}) - $signed({1'b0, i_query.radius_lower});
            r1_dgr_h <= $signed({1'b0, i_query.slow_upper_right})
                        - $signed({1'b0, i_query.slow_lower_right});
            r1_dgr_l <= $signed({1'b0, i_query.slow_upper_left})
                        - $signed({1'b0, i_query.slow_lower_left});
            r1_dga_h <= $signed({1'b0, i_query.slow_upper_right})
                        - $signed({1'b0, i_query.slow_upper_left});
            r1_dga_l <= $signed({1'b0, i_query.slow_lower_right})
                        - $signed({1'b0, i_query.slow_lower_left});
            r1_slow[0] <= i_query.slow_lower_left;
            r1_slow[1] <= i_query.slow_lower_right;
            r1_slow[2] <= i_query.slow_upper_left;
            r1_slow[3] <= i_query.slow_upper_right;
            r1_fault <= (i_query.radius_upper == i_query.radius_lower)
                        || (i_query.angle_right == i_query.angle_left);

            r2_den  <= r1_da * r1_dr;
            r2_w[0] <= r1_wal * r1_wrl;
            r2_w[1] <= r1_wah * r1_wrl;
            r2_w[2] <= r1_wal * r1_wrh;
            r2_w[3] <= r1_wah * r1_wrh;
            r2_gr1  <= r1_dgr_h * r1_wah;
            r2_gr2  <= r1_dgr_l * r1_wal;
            r2_ga1  <= r1_dga_h * r1_wrh;
            r2_ga2  <= r1_dga_l * r1_wrl;
            r2_slow <= r1_slow;
            r2_fault <= r1_fault;

            for (int k = 0; k < 4; k++) begin
                r3_ph[k] <= $signed({1'b0, r2_slow[k]}) * $signed(r2_w[k][42:22]);
                r3_pl[k] <= $signed({1'b0, r2_slow[k]}) * $signed({1'b0, r2_w[k][21:0]});
            end
            r3_gr    <= 44'(r2_gr1) + 44'(r2_gr2);
            r3_ga    <= 44'(r2_ga1) + 44'(r2_ga2);
            r3_den   <= r2_den;
            r3_fault <= r2_fault;

            r4_hs    <= 44'(r3_ph[0]) + 44'(r3_ph[1]) + 44'(r3_ph[2]) + 44'(r3_ph[3]);
            r4_ls    <= 46'(r3_pl[0]) + 46'(r3_pl[1]) + 46'(r3_pl[2]) + 46'(r3_pl[3]);
            r4_gr    <= r3_gr;
            r4_ga    <= r3_ga;
            r4_den   <= r3_den;
            r4_fault <= r3_fault;

            r5_num[LANE_SLOW] <= (NUM_W'(r4_hs) <<< 22) + NUM_W'(r4_ls);
            r5_num[LANE_GR]   <= NUM_W'(r4_gr);
            r5_num[LANE_GA]   <= NUM_W'(r4_ga);
            r5_den            <= r4_den;
            r5_fault          <= r4_fault;
        end
    end

    assign o_valid = r_v[4];
    assign o_num   = r5_num;
    assign o_den   = r5_den;
    assign o_fault = r5_fault;

endmodule

// ----- hdl/bigi_div.sv -----
// Pipelined restoring divider, one quotient bit a stage, shared denominator, three lanes.
module bigi_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  bigi_pkg::t_num               i_num [bigi_pkg::LANES],
    input  bigi_pkg::t_den               i_den,
    input  logic                         i_fault,
    output logic                         o_valid,
    output logic [bigi_pkg::QUO_W-1:0]   o_q [bigi_pkg::LANES],
    output logic [bigi_pkg::LANES-1:0]   o_ov,
    output logic [bigi_pkg::LANES-1:0]   o_neg,
    output logic                         o_fault
);
    import bigi_pkg::*;

    localparam int STAGES = QUO_W + 3;

    logic [STAGES-1:0] r_v;
    logic [STAGES-1:0] r_fault;

    logic [NUM_W-2:0]  ra_un [LANES];
    logic [LANES-1:0]  ra_neg;
    logic [MAG_W-1:0]  ra_ud;

    logic [NUM_W-1:0]  rb_n [LANES];
    logic [LANES-1:0]  rb_neg;
    logic [MAG_W-1:0]  rb_ud;

    logic [REM_W-1:0]  r_rem [QUO_W+1][LANES];
    logic [QUO_W-1:0]  r_q   [QUO_W+1][LANES];
    logic [LANES-1:0]  r_ov  [QUO_W+1];
    logic [LANES-1:0]  r_neg [QUO_W+1];
    logic [MAG_W-1:0]  r_ud  [QUO_W+1];

    logic [REM_W-1:0]  w_trial [QUO_W];
    logic [LANES-1:0]  w_take  [QUO_W];

    always_comb begin
        for (int s = 0; s < QUO_W; s++) begin
            w_trial[s] = REM_W'(r_ud[s]) << (QUO_W - 1 - s);
            for (int k = 0; k < LANES; k++) begin
                w_take[s][k] = r_rem[s][k] >= w_trial[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fault <= {r_fault[STAGES-2:0], i_fault};

            ra_ud <= i_den[DEN_W-1] ? MAG_W'(-i_den) : MAG_W'(i_den);
            for (int k = 0; k < LANES; k++) begin
                ra_un[k]  <= i_num[k][NUM_W-1] ? (NUM_W-1)'(-i_num[k]) : (NUM_W-1)'(i_num[k]);
                ra_neg[k] <= i_num[k][NUM_W-1] ^ i_den[DEN_W-1];
            end

            rb_ud  <= ra_ud;
            rb_neg <= ra_neg;
            for (int k = 0; k < LANES; k++) begin
                rb_n[k] <= ({1'b0, ra_un[k]} << LANE_SHIFT[k]) + NUM_W'(ra_ud >> 1);
            end

            r_ud[0]  <= rb_ud;
            r_neg[0] <= rb_neg;
            for (int k = 0; k < LANES; k++) begin
                r_rem[0][k] <= REM_W'(rb_n[k]);
                r_q[0][k]   <= '0;
                r_ov[0][k]  <= REM_W'(rb_n[k]) >= {rb_ud, {QUO_W{1'b0}}};
            end

            for (int s = 0; s < QUO_W; s++) begin
                r_ud[s+1]  <= r_ud[s];
                r_neg[s+1] <= r_neg[s];
                r_ov[s+1]  <= r_ov[s];
                for (int k = 0; k < LANES; k++) begin
                    r_rem[s+1][k] <= w_take[s][k] ? r_rem[s][k] - w_trial[s] : r_rem[s][k];
                    r_q[s+1][k]   <= r_q[s][k] | (QUO_W'(w_take[s][k]) << (QUO_W - 1 - s));
                end
            end
        end
    end

    assign o_valid = r_v[STAGES-1];
    assign o_fault = r_fault[STAGES-1];
    assign o_q     = r_q[QUO_W];
    assign o_ov    = r_ov[QUO_W];
    assign o_neg   = r_neg[QUO_W];

endmodule

// ----- hdl/bilinear_interp_with_gradient.sv -----
// Top level of the bilinear slowness interpolator with radius and angle gradients.
//
//  channel  direction  handshake          word
//  query    in         i_valid / o_stall  cell bounds, corner slownesses, point
//  result   out        o_valid / i_stall  slowness, two gradients, area fault
//
// One word is taken every cycle while o_stall is low; each result passes through
// 5 front-end stages, 35 divider stages and 1 output register.
// The divider, one quotient bit a stage, makes up most of that depth.
// Reset clears all valid bits; no clearing pass is needed.
// A stalled result freezes the pipeline; a skid register takes one more word.
module bilinear_interp_with_gradient (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [bigi_pkg::SLOW_W-1:0]          i_slow_upper_left,
    input  logic [bigi_pkg::SLOW_W-1:0]          i_slow_upper_right,
    input  logic [bigi_pkg::SLOW_W-1:0]          i_slow_lower_left,
    input  logic [bigi_pkg::SLOW_W-1:0]          i_slow_lower_right,
    input  logic [bigi_pkg::RAD_W-1:0]           i_radius_upper,
    input  logic [bigi_pkg::RAD_W-1:0]           i_radius_lower,
    input  logic [bigi_pkg::ANG_W-1:0]           i_angle_left,
    input  logic [bigi_pkg::ANG_W-1:0]           i_angle_right,
    input  logic [bigi_pkg::RAD_W-1:0]           i_point_radius,
    input  logic [bigi_pkg::ANG_W-1:0]           i_point_angle,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [bigi_pkg::SLOW_W-1:0]          o_slowness,
    output logic signed [bigi_pkg::GRAD_W-1:0]   o_grad_radius,
    output logic signed [bigi_pkg::GRAD_W-1:0]   o_grad_angle,
    output logic                                 o_area_fault
);
    import bigi_pkg::*;

    t_query             w_port;
    t_query             r_skid;
    logic               r_skid_valid;
    logic               w_en;
    t_query             w_query;
    logic               w_query_valid;

    logic               w_f_valid;
    t_num               w_f_num [LANES];
    t_den               w_f_den;
    logic               w_f_fault;

    logic               w_d_valid;
    logic [QUO_W-1:0]   w_d_q [LANES];
    logic [LANES-1:0]   w_d_ov;
    logic [LANES-1:0]   w_d_neg;
    logic               w_d_fault;

    logic [SLOW_W-1:0]  w_slow;
    logic [GRAD_W-1:0]  w_grad [LANES];

    logic               r_out_valid;
    logic [SLOW_W-1:0]  r_slowness;
    logic [GRAD_W-1:0]  r_grad_radius;
    logic [GRAD_W-1:0]  r_grad_angle;
    logic               r_area_fault;

    assign w_port = '{
        slow_upper_left:  i_slow_upper_left,
        slow_upper_right: i_slow_upper_right,
        slow_lower_left:  i_slow_lower_left,
        slow_lower_right: i_slow_lower_right,
        radius_upper:     i_radius_upper,
        radius_lower:     i_radius_lower,
        angle_left:       i_angle_left,
        angle_right:      i_angle_right,
        point_radius:     i_point_radius,
        point_angle:      i_point_angle
    };

    assign w_en          = !r_out_valid || !i_stall;
    assign o_stall       = r_skid_valid;
    assign w_query       = r_skid_valid ? r_skid : w_port;
    assign w_query_valid = r_skid_valid || i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (w_en) begin
            r_skid_valid <= 1'b0;
        end else if (i_valid && !r_skid_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_en && !r_skid_valid) begin
            r_skid <= w_port;
        end
    end

    bigi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_query_valid),
        .i_query (w_query),
        .o_valid (w_f_valid),
        .o_num   (w_f_num),
        .o_den   (w_f_den),
        .o_fault (w_f_fault)
    );

    bigi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_valid),
        .i_num   (w_f_num),
        .i_den   (w_f_den),
        .i_fault (w_f_fault),
        .o_valid (w_d_valid),
        .o_q     (w_d_q),
        .o_ov    (w_d_ov),
        .o_neg   (w_d_neg),
        .o_fault (w_d_fault)
    );

    always_comb begin
        if (w_d_fault || w_d_neg[LANE_SLOW]) begin
            w_slow = '0;
        end else if (w_d_ov[LANE_SLOW] || (w_d_q[LANE_SLOW] > QUO_W'(SLOW_MAX))) begin
            w_slow = SLOW_MAX;
        end else begin
            w_slow = w_d_q[LANE_SLOW][SLOW_W-1:0];
        end
        w_grad[LANE_SLOW] = '0;
        for (int k = LANE_GR; k < LANES; k++) begin
            if (w_d_fault) begin
                w_grad[k] = '0;
            end else if (!w_d_neg[k]) begin
                w_grad[k] = (w_d_ov[k] || (w_d_q[k] > QUO_W'(GRAD_MAX))) ? GRAD_MAX
                                                                         : GRAD_W'(w_d_q[k]);
            end else begin
                w_grad[k] = (w_d_ov[k] || (w_d_q[k] > QUO_W'(GRAD_MIN))) ? GRAD_MIN
                                                                         : GRAD_W'(-w_d_q[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_slowness    <= w_slow;
            r_grad_radius <= w_grad[LANE_GR];
            r_grad_angle  <= w_grad[LANE_GA];
            r_area_fault  <= w_d_fault;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_slowness    = r_slowness;
    assign o_grad_radius = $signed(r_grad_radius);
    assign o_grad_angle  = $signed(r_grad_angle);
    assign o_area_fault  = r_area_fault;

`ifndef NO_ASSERTIONS
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_area_fault) |-> (o_slowness == '0 && o_grad_radius == '0
                                        && o_grad_angle == '0))
        else $error("faulted result carries non-zero values");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && w_en) |=> !r_skid_valid)
        else $error("skid word not drained when pipeline advanced");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(r_slowness) && $stable(r_area_fault)))
        else $error("stalled result changed");
`endif

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the bilinear slowness interpolator with gradients.
`timescale 1ns / 1ps

module testbench;
    import bigi_pkg::*;

    localparam int LATENCY   = 41;
    localparam int MAX_CYCLE = 2000000;
    localparam int QUERY_W   = $bits(t_query);

    typedef struct packed {
        logic [SLOW_W-1:0] slowness;
        logic [GRAD_W-1:0] grad_radius;
        logic [GRAD_W-1:0] grad_angle;
        logic              area_fault;
    } t_interp;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic o_stall, o_valid, o_area_fault;
    logic [SLOW_W-1:0] i_slow_upper_left = '0, i_slow_upper_right = '0;
    logic [SLOW_W-1:0] i_slow_lower_left = '0, i_slow_lower_right = '0;
    logic [RAD_W-1:0] i_radius_upper = '0, i_radius_lower = '0, i_point_radius = '0;
    logic [ANG_W-1:0] i_angle_left = '0, i_angle_right = '0, i_point_angle = '0;
    logic [SLOW_W-1:0] o_slowness;
    logic signed [GRAD_W-1:0] o_grad_radius, o_grad_angle;

    t_interp pending_interp[$];
    int error_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_cycles = 0;

    bilinear_interp_with_gradient DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint round_div(longint n, int sh, longint d);
        logic neg;
        logic [127:0] un, ud, q;
        neg = (n < 0) != (d < 0);
        un = (n < 0) ? -n : n;
        ud = (d < 0) ? -d : d;
        un = un << sh;
        q = (un + ud / 2) / ud;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic t_interp interpolate(t_query q);
        t_interp r;
        longint uls, urs, lls, lrs, ru, rl, al, ar, pr, pa;
        longint dr, da, den, wal, wah, wrl, wrh, num;
        uls = q.slow_upper_left;  urs = q.slow_upper_right;
        lls = q.slow_lower_left;  lrs = q.slow_lower_right;
        ru = q.radius_upper;  rl = q.radius_lower;  pr = q.point_radius;
        al = q.angle_left;    ar = q.angle_right;   pa = q.point_angle;
        dr = ru - rl;
        da = ar - al;
        r = '0;
        if (dr == 0 || da == 0) begin
            r.area_fault = 1'b1;
            return r;
        end
        den = da * dr;
        wal = ar - pa;  wah = pa - al;  wrl = ru - pr;  wrh = pr - rl;
        num = lls * (wal * wrl) + lrs * (wah * wrl) + uls * (wal * wrh) + urs * (wah * wrh);
        r.slowness = SLOW_W'(clip(round_div(num, 0, den), 0, 64'd1048575));
        num = (urs - lrs) * wah + (uls - lls) * wal;
        r.grad_radius = GRAD_W'(clip(round_div(num, 16, den),
                                     -64'sd2147483648, 64'sd2147483647));
        num = (urs - uls) * wrh + (lrs - lls) * wrl;
        r.grad_angle = GRAD_W'(clip(round_div(num, 20, den),
                                    -64'sd2147483648, 64'sd2147483647));
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("Mismatch in %s: got %0d, expected %0d at cycle %0d",
                 what, got, want, cycle_count);
        error_count++;
    endtask

    task automatic send_word(t_query q);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        {i_slow_upper_left, i_slow_upper_right, i_slow_lower_left, i_slow_lower_right,
         i_radius_upper, i_radius_lower, i_angle_left, i_angle_right,
         i_point_radius, i_point_angle} <= q;
        do @(posedge i_clk); while (o_stall);
        pending_interp.push_back(interpolate(q));
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE) begin
            $display("Timeout at cycle %0d", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_interp.size() == 0) begin
                $display("Unexpected result word at cycle %0d", cycle_count);
                error_count++;
            end else begin
                t_interp e;
                e = pending_interp.pop_front();
                if (o_slowness !== e.slowness)
                    report_mismatch("slowness", o_slowness, e.slowness);
                if (o_grad_radius !== e.grad_radius)
                    report_mismatch("grad_radius", o_grad_radius, $signed(e.grad_radius));
                if (o_grad_angle !== e.grad_angle)
                    report_mismatch("grad_angle", o_grad_angle, $signed(e.grad_angle));
                if (o_area_fault !== e.area_fault)
                    report_mismatch("area_fault", o_area_fault, e.area_fault);
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
        end
    end

    function automatic t_query random_query(logic wide);
        t_query q;
        int span_r, span_a;
        q.slow_upper_left  = SLOW_W'($urandom);
        q.slow_upper_right = SLOW_W'($urandom);
        q.slow_lower_left  = SLOW_W'($urandom);
        q.slow_lower_right = SLOW_W'($urandom);
        q.radius_lower = RAD_W'($urandom);
        q.angle_left   = ANG_W'($urandom);
        case ($urandom_range(9))
            0: begin
                q = QUERY_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom});
            end
            1: begin
                q.radius_upper = q.radius_lower;
                q.angle_right  = ANG_W'($urandom);
                q.point_radius = RAD_W'($urandom);
                q.point_angle  = ANG_W'($urandom);
            end
            default: begin
                q.radius_lower = RAD_W'($urandom_range(1630976));
                q.angle_left   = ANG_W'($urandom_range(737280));
                span_r = wide ? int'($urandom_range(400000)) : int'($urandom_range(1, 2000));
                span_a = wide ? int'($urandom_range(400000)) : int'($urandom_range(1, 2000));
                if ($urandom_range(3) == 0) span_r = -span_r;
                if ($urandom_range(3) == 0) span_a = -span_a;
                q.radius_upper = RAD_W'(int'(q.radius_lower) + span_r);
                q.angle_right  = ANG_W'(int'(q.angle_left) + span_a);
                q.point_radius = RAD_W'(int'(q.radius_lower) + int'($urandom_range(2500)) - 200);
                q.point_angle  = ANG_W'(int'(q.angle_left) + int'($urandom_range(2500)) - 200);
            end
        endcase
        return q;
    endfunction

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_interp.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 5) @(negedge i_clk);
    endtask

    task automatic test_corners();
        t_query q;
        q = '0;
        send_word(q);
        q = '1;
        send_word(q);
        q = '0;
        q.radius_upper = 21'h1FFFFF;  q.angle_right = 20'hFFFFF;
        q.slow_upper_right = '1;  q.point_radius = '1;  q.point_angle = '1;
        send_word(q);
        q.radius_upper = 21'd1630976; q.radius_lower = 0;
        q.angle_right = 20'd737280;   q.angle_left = 0;
        q.slow_upper_left = '1;  q.slow_lower_right = '1;  q.slow_lower_left = 0;
        q.point_radius = 21'd815488;  q.point_angle = 20'd368640;
        send_word(q);
        q.point_radius = 0;  q.point_angle = 0;
        send_word(q);
        q.radius_upper = 1;  q.radius_lower = 0;  q.angle_right = 1;  q.angle_left = 0;
        q.point_radius = '1;  q.point_angle = '1;
        send_word(q);
        q.radius_upper = 0;  q.radius_lower = 1;
        send_word(q);
        q.angle_right = 0;  q.angle_left = 20'hFFFFF;  q.point_angle = 3;
        send_word(q);
        q.radius_upper = q.radius_lower;
        send_word(q);
        q.radius_upper = 100;  q.radius_lower = 0;  q.angle_left = q.angle_right;
        send_word(q);
        q = '0;
        q.radius_upper = 2;  q.angle_right = 2;  q.point_radius = 1;  q.point_angle = 1;
        q.slow_upper_left = 1;  q.slow_lower_right = 0;
        send_word(q);
        q.slow_upper_left = 3;  q.slow_upper_right = 2;
        send_word(q);
        wait_drained();
    endtask

    task automatic test_random(int count, int idle_pct, int stall);
        send_idle_pct = idle_pct;
        stall_pct = stall;
        repeat (count) send_word(random_query($urandom_range(9) == 0));
        wait_drained();
        send_idle_pct = 0;
        stall_pct = 0;
    endtask

    task automatic test_backpressure();
        hold_cycles = 300;
        repeat (120) send_word(random_query(1'b0));
        wait_drained();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_corners();
        test_random(400, 0, 0);
        test_random(350, 73, 0);
        test_random(350, 0, 73);
        test_random(350, 32, 32);
        test_backpressure();
        test_random(200, 0, 0);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
